>>> rtl/lfo_modulated_chorus_assert.svh
// Assertion macros for the chorus block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LFO_MODULATED_CHORUS_ASSERT_SVH
`define LFO_MODULATED_CHORUS_ASSERT_SVH

// pre holds at one edge -> post holds at the next
`define LMC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("chorus assertion failed");

// pre holds -> post holds at the same edge
`define LMC_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("chorus assertion failed");

`endif

>>> rtl/lfomc_pkg.sv
// Shared types, constants and the sine table for the chorus block.
// No dependencies; imported by every module of the block.
package lfomc_pkg;

  localparam int DELAY_DEPTH     = 4096;
  localparam int SINE_TABLE_SIZE = 256;

  localparam int AW     = $clog2(DELAY_DEPTH);
  localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
  localparam int SIW    = $clog2(SINE_TABLE_SIZE);
  localparam int PH_W   = 24;
  localparam int DW     = AW + 8;
  localparam int DIV_W  = 34;
  localparam int DEN_W  = 24;
  localparam int MS_W   = 30;
  localparam int TV_W   = 26;
  localparam int ACC_W  = 42;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_RATE  = 2'd1;
  localparam logic [1:0] CFG_DEPTH = 2'd2;
  localparam logic [1:0] CFG_SR    = 2'd3;

  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_DUAL   = 2'd2;

  localparam logic [9:0]  RATE_MIN  = 10'd10;
  localparam logic [9:0]  RATE_MAX  = 10'd1000;
  localparam logic [8:0]  DEPTH_MAX = 9'd256;

  // exact floor(n / 1000) and floor(n / 5000) for n < 2^31 by reciprocal multiply
  localparam logic [31:0] RECIP_A    = 32'd2199023256;  // ceil(2^41 / 1000)
  localparam logic [31:0] RECIP_B    = 32'd3518437209;  // ceil(2^44 / 5000)
  localparam int          RECIP_SH_A = 41;
  localparam int          RECIP_SH_B = 44;

  localparam logic signed [MS_W-1:0] MS_A_BASE = MS_W'(5 * (1 << 23));
  localparam logic signed [MS_W-1:0] MS_B_BASE = MS_W'(5 * (13 << 22));

  localparam logic signed [15:0] W_07 = 16'sd22938;
  localparam logic signed [15:0] W_03 = 16'sd9830;
  localparam logic signed [15:0] W_06 = 16'sd19661;
  localparam logic signed [15:0] W_01 = 16'sd3277;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_WRITE, OP_DIV_STEP, OP_PHASE, OP_SINE, OP_MS, OP_MSR,
    OP_DIV_DLY, OP_CLAMP, OP_RD1, OP_RD2, OP_TAP, OP_MAC, OP_RESULT
  } op_t;

  typedef enum logic [1:0] {SRC_X, SRC_VA, SRC_VB} src_t;
  typedef enum logic [1:0] {WT_07, WT_03, WT_06, WT_01} wt_t;

  typedef struct packed {
    op_t  op;
    logic tap;      // 0 tap A, 1 tap B
    logic acc_sel;  // 0 left, 1 right
    logic acc_clr;
    src_t src;
    wt_t  wt;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic dual;
    logic div_busy;
  } dp_stat_t;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_SIZE];

  // Q30 series sine, rounded to Q15, evaluated at elaboration only
  function automatic logic signed [15:0] sine_entry(input int unsigned idx);
    logic [63:0] a, w, x, x2, t, s, q;
    logic [1:0]  quad;
    a    = (64'(idx) << 32) / 64'(SINE_TABLE_SIZE);
    quad = a[31:30];
    w    = a & (Q30_ONE - 64'd1);
    if (quad[0]) w = Q30_ONE - w;
    x  = (w * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return quad[1] ? -$signed(16'(q)) : $signed(16'(q));
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) r[i] = sine_entry(i);
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/lfomc_div.sv
// Restoring divider, one quotient bit per clock.
// Depends on lfomc_pkg for widths.
module lfomc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lfomc_pkg::DIV_W-1:0] num,
  input  logic [lfomc_pkg::DEN_W-1:0] den,
  output logic                        busy,
  output logic [lfomc_pkg::DIV_W-1:0] quot
);
  import lfomc_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   rem_sh;

  always_comb begin
    rem_sh   = {rem_r, q_r[DIV_W-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

>>> rtl/lfomc_datapath.sv
// Datapath: config registers, delay line memory, LFO phases, tap math, mixer.
// Depends on lfomc_pkg and lfomc_div.
module lfomc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [16:0]         cfg_wdata,
  input  logic signed [15:0]  in_sample,
  input  lfomc_pkg::dp_cmd_t  cmd,
  output lfomc_pkg::dp_stat_t stat,
  output logic signed [15:0]  left_out,
  output logic signed [15:0]  right_out
);
  import lfomc_pkg::*;

  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rs;
    rs = (acc + ACC_W'(1 << 22)) >>> 23;
    if (rs > ACC_W'(32767)) return 16'sh7fff;
    if (rs < -ACC_W'(32768)) return -16'sh8000;
    return rs[15:0];
  endfunction

  // config
  logic [1:0]  mode_r;
  logic [9:0]  rate_r;
  logic [8:0]  depth_r;
  logic [16:0] sr_r;
  logic [9:0]  rate_c;
  logic [8:0]  depth_c;

  // state
  logic [AW-1:0]     wp_r;
  logic [FILL_W-1:0] fill_r;
  logic [PH_W-1:0]   pha_r, phb_r;

  // payload
  logic signed [15:0]      x_r, sa_r, sb_r, x1_r, rdata_r;
  logic signed [MS_W-1:0]  ms_r;
  logic [31:0]             dnum_r;
  logic [63:0]             prod_r;
  logic [AW-1:0]           p1_r;
  logic [7:0]              frac_r;
  logic                    v1_r, v2_r;
  logic signed [TV_W-1:0]  va_r, vb_r;
  logic signed [ACC_W-1:0] accl_r, accr_r;
  logic signed [15:0]      outl_r, outr_r;
  logic signed [15:0]      mem [DELAY_DEPTH];

  // divider, used for the LFO phase step only
  logic             div_start, div_busy;
  logic [DIV_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0] div_den;

  assign rate_c  = (rate_r < RATE_MIN) ? RATE_MIN : (rate_r > RATE_MAX) ? RATE_MAX : rate_r;
  assign depth_c = (depth_r > DEPTH_MAX) ? DEPTH_MAX : depth_r;

  assign div_start = (cmd.op == OP_DIV_STEP);
  assign div_num   = DIV_W'(rate_c) << PH_W;
  assign div_den   = DEN_W'(24'(sr_r) * 24'd100);

  lfomc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign stat.bypass   = !((mode_r == MODE_SINGLE) || (mode_r == MODE_DUAL));
  assign stat.dual     = (mode_r == MODE_DUAL);
  assign stat.div_busy = div_busy;

  // combinational helpers
  logic [PH_W-1:0]          step;
  logic [PH_W+SIW-1:0]      pma, pmb;
  logic signed [15:0]       s_sel;
  logic signed [25:0]       sd_p;
  logic [MS_W+16:0]         msr_p;
  logic [63:0]              recip_p;
  logic [31:0]              dq;
  logic [DW-1:0]            d_c;
  logic [AW-1:0]            di;
  logic [AW:0]              p1_t;
  logic [AW-1:0]            p2;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [15:0]       x2;
  logic signed [16:0]       diff;
  logic signed [25:0]       fm;
  logic signed [TV_W-1:0]   a_src;
  logic signed [15:0]       w_c;
  logic signed [ACC_W-1:0]  mac_p, acc_base;

  always_comb begin
    step  = (sr_r == '0) ? '0 : div_quot[PH_W-1:0];
    pma   = (PH_W+SIW)'(pha_r) * (PH_W+SIW)'(SINE_TABLE_SIZE);
    pmb   = (PH_W+SIW)'(phb_r) * (PH_W+SIW)'(SINE_TABLE_SIZE);
    s_sel = cmd.tap ? sb_r : sa_r;
    sd_p  = s_sel * $signed({1'b0, depth_c});
    msr_p = (MS_W+17)'(ms_r[MS_W-2:0]) * (MS_W+17)'(sr_r);

    // delay in Q8: numerator below 2^31, 32 x 32 reciprocal product
    recip_p = {32'd0, dnum_r} * {32'd0, (cmd.tap ? RECIP_B : RECIP_A)};
    dq      = cmd.tap ? 32'(prod_r >> RECIP_SH_B) : 32'(prod_r >> RECIP_SH_A);

    if (dq < 32'd256) d_c = DW'(256);
    else if (dq > 32'((DELAY_DEPTH - 1) * 256)) d_c = DW'((DELAY_DEPTH - 1) * 256);
    else d_c = dq[DW-1:0];
    di   = d_c[DW-1:8];
    p1_t = (AW+1)'(wp_r) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(di);
    if (p1_t >= (AW+1)'(DELAY_DEPTH)) p1_t = p1_t - (AW+1)'(DELAY_DEPTH);

    p2      = (p1_r == '0) ? AW'(DELAY_DEPTH - 1) : p1_r - AW'(1);
    rd_en   = (cmd.op == OP_RD1) || (cmd.op == OP_RD2);
    rd_addr = (cmd.op == OP_RD1) ? p1_r : p2;

    x2   = v2_r ? rdata_r : 16'sd0;
    diff = 17'(x2) - 17'(x1_r);
    fm   = $signed({1'b0, frac_r}) * diff;

    case (cmd.src)
      SRC_X:   a_src = TV_W'(x_r) <<< 8;
      SRC_VA:  a_src = va_r;
      SRC_VB:  a_src = vb_r;
      default: a_src = '0;
    endcase
    case (cmd.wt)
      WT_07:   w_c = W_07;
      WT_03:   w_c = W_03;
      WT_06:   w_c = W_06;
      default: w_c = W_01;
    endcase
    mac_p    = a_src * w_c;
    acc_base = cmd.acc_clr ? '0 : (cmd.acc_sel ? accr_r : accl_r);
  end

  // control-side state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd0;
      rate_r  <= 10'd80;
      depth_r <= 9'd128;
      sr_r    <= 17'd44100;
      wp_r    <= '0;
      fill_r  <= '0;
      pha_r   <= '0;
      phb_r   <= PH_W'(24'h800000);
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MODE:  mode_r  <= cfg_wdata[1:0];
          CFG_RATE:  rate_r  <= cfg_wdata[9:0];
          CFG_DEPTH: depth_r <= cfg_wdata[8:0];
          CFG_SR:    sr_r    <= cfg_wdata;
          default:   ;
        endcase
      end
      if (cmd.op == OP_WRITE) begin
        wp_r <= (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
        if (fill_r != FILL_W'(DELAY_DEPTH)) fill_r <= fill_r + FILL_W'(1);
      end
      if (cmd.op == OP_PHASE) begin
        pha_r <= pha_r + step;
        phb_r <= phb_r + step;
      end
    end
  end

  // delay line: one write or one registered read per clock
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) mem[wp_r] <= x_r;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: x_r <= in_sample;
      OP_SINE: begin
        sa_r <= SINE_ROM[pma[PH_W +: SIW]];
        sb_r <= SINE_ROM[pmb[PH_W +: SIW]];
      end
      OP_MS: ms_r <= cmd.tap ? MS_B_BASE + (MS_W'(sd_p) <<< 3)
                             : MS_A_BASE + (MS_W'(sd_p) <<< 1);
      OP_MSR: dnum_r <= msr_p[MS_W+16:15];
      OP_DIV_DLY: prod_r <= recip_p;
      OP_CLAMP: begin
        p1_r   <= p1_t[AW-1:0];
        frac_r <= d_c[7:0];
        v1_r   <= ((FILL_W+1)'(di) <= (FILL_W+1)'(fill_r));
        v2_r   <= ((FILL_W+1)'(di) + (FILL_W+1)'(1) <= (FILL_W+1)'(fill_r));
      end
      OP_RD2: x1_r <= v1_r ? rdata_r : 16'sd0;
      OP_TAP: begin
        if (cmd.tap) vb_r <= (TV_W'(x1_r) <<< 8) + TV_W'(fm);
        else         va_r <= (TV_W'(x1_r) <<< 8) + TV_W'(fm);
      end
      OP_MAC: begin
        if (cmd.acc_sel) accr_r <= acc_base + mac_p;
        else             accl_r <= acc_base + mac_p;
      end
      OP_RESULT: begin
        outl_r <= stat.bypass ? x_r : round_sat(accl_r);
        outr_r <= stat.bypass ? x_r : stat.dual ? round_sat(accr_r) : round_sat(accl_r);
      end
      default: ;
    endcase
  end

  assign left_out  = outl_r;
  assign right_out = outr_r;

endmodule

>>> rtl/lfomc_ctrl.sv
// Sequencer for the chorus datapath and owner of the output valid flag.
// Depends on lfomc_pkg.
module lfomc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  lfomc_pkg::dp_stat_t stat,
  output lfomc_pkg::dp_cmd_t  cmd
);
  import lfomc_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000_0000_0000_0001,
    S_WRITE = 15'b000_0000_0000_0010,
    S_DIVS  = 15'b000_0000_0000_0100,
    S_DIVSW = 15'b000_0000_0000_1000,
    S_PHASE = 15'b000_0000_0001_0000,
    S_SINE  = 15'b000_0000_0010_0000,
    S_MS    = 15'b000_0000_0100_0000,
    S_MSR   = 15'b000_0000_1000_0000,
    S_DIVD  = 15'b000_0001_0000_0000,
    S_CLAMP = 15'b000_0010_0000_0000,
    S_RD1   = 15'b000_0100_0000_0000,
    S_RD2   = 15'b000_1000_0000_0000,
    S_TAP   = 15'b001_0000_0000_0000,
    S_MIX   = 15'b010_0000_0000_0000,
    S_DONE  = 15'b100_0000_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic       tap_r, tap_nxt;
  logic [2:0] mix_r, mix_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       mix_last;

  always_comb begin
    state_nxt   = state_r;
    tap_nxt     = tap_r;
    mix_nxt     = mix_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    mix_last    = 1'b0;
    cmd         = '0;
    cmd.op      = OP_NOP;
    cmd.tap     = tap_r;
    cmd.src     = SRC_X;
    cmd.wt      = WT_07;

    // mixer program: single tap 2 steps, dual 6 steps
    if (!stat.dual) begin
      case (mix_r)
        3'd0:    begin cmd.acc_clr = 1'b1; cmd.src = SRC_X;  cmd.wt = WT_07; end
        default: begin cmd.src = SRC_VA; cmd.wt = WT_03; mix_last = 1'b1; end
      endcase
    end else begin
      case (mix_r)
        3'd0: begin cmd.acc_clr = 1'b1; cmd.src = SRC_X; cmd.wt = WT_06; end
        3'd1: begin cmd.src = SRC_VA; cmd.wt = WT_03; end
        3'd2: begin cmd.src = SRC_VB; cmd.wt = WT_01; end
        3'd3: begin
          cmd.acc_sel = 1'b1; cmd.acc_clr = 1'b1; cmd.src = SRC_X; cmd.wt = WT_06;
        end
        3'd4: begin cmd.acc_sel = 1'b1; cmd.src = SRC_VB; cmd.wt = WT_03; end
        default: begin
          cmd.acc_sel = 1'b1; cmd.src = SRC_VA; cmd.wt = WT_01; mix_last = 1'b1;
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.op    = OP_WRITE;
        tap_nxt   = 1'b0;
        state_nxt = stat.bypass ? S_DONE : S_DIVS;
      end
      S_DIVS: begin
        cmd.op    = OP_DIV_STEP;
        state_nxt = S_DIVSW;
      end
      S_DIVSW: if (!stat.div_busy) state_nxt = S_PHASE;
      S_PHASE: begin
        cmd.op    = OP_PHASE;
        state_nxt = S_SINE;
      end
      S_SINE: begin
        cmd.op    = OP_SINE;
        state_nxt = S_MS;
      end
      S_MS: begin
        cmd.op    = OP_MS;
        state_nxt = S_MSR;
      end
      S_MSR: begin
        cmd.op    = OP_MSR;
        state_nxt = S_DIVD;
      end
      S_DIVD: begin
        cmd.op    = OP_DIV_DLY;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.op    = OP_RD1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.op    = OP_RD2;
        state_nxt = S_TAP;
      end
      S_TAP: begin
        cmd.op = OP_TAP;
        if (stat.dual && !tap_r) begin
          tap_nxt   = 1'b1;
          state_nxt = S_MS;
        end else begin
          mix_nxt   = 3'd0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        cmd.op = OP_MAC;
        if (mix_last) state_nxt = S_DONE;
        else mix_nxt = mix_r + 3'd1;
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          cmd.op     = OP_RESULT;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tap_r    <= 1'b0;
      mix_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tap_r    <= tap_nxt;
      mix_r    <= mix_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

endmodule

>>> rtl/lfo_modulated_chorus.sv
// Top level of the LFO modulated stereo chorus.
// Depends on lfomc_pkg, lfomc_ctrl, lfomc_datapath (with lfomc_div) and the assert header.
`include "lfo_modulated_chorus_assert.svh"

// Mono in, stereo out chorus. Each input word is one signed 16-bit sample; it
// is written into a 4096-entry delay line and one stereo word comes back per
// input word. Items are handled one at a time, in bypass (mode 0 or 3), in
// single-tap mode or in dual-tap mode. The work on a word is the bit-serial
// divider for the LFO phase step, then per tap the delay conversion by
// reciprocal multiply, two memory reads and interpolation, then 2 or 6 mixer
// multiply-accumulate steps; bypass skips all of it. The result sits in an
// output register, so the next sample is taken while the previous word is
// still waiting for the sink; a word finished while that register is full
// stalls until the sink takes it. The delay line needs no clearing pass
// after reset: a fill count marks unwritten entries, which read as zero.
// Configuration writes must only be made while no sample is in flight.
module lfo_modulated_chorus (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,     // 0 mode, 1 rate_centihz, 2 depth_q8, 3 sample_rate_hz
  input  logic [16:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] in_sample
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata     // [15:0] left_out, [31:16] right_out
);
  import lfomc_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic signed [15:0] left_out, right_out;

  // sequencer: steps the datapath through one sample
  lfomc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: config, delay line, LFOs, taps, mixer, result register
  lfomc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_sample ($signed(in_tdata)),
    .cmd       (cmd),
    .stat      (stat),
    .left_out  (left_out),
    .right_out (right_out)
  );

  assign out_tdata = {right_out, left_out};

  // one word in flight: an accepted word closes the input until its result is out
  `LMC_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  // ready only drops because a word was taken
  `LMC_ASSERT_NOW(a_ready_drop, $fell(in_tready), $past(in_tvalid))
  // a result appears only at the end of work on a word
  `LMC_ASSERT_NOW(a_result_from_work, $rose(out_tvalid), $past(!in_tready))

endmodule

>>> tb/lfo_modulated_chorus_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lfo_modulated_chorus: directed table, then random phases.
// Depends on lfomc_pkg (register codes, modes, sizes) and the RTL of the block.
module lfo_modulated_chorus_tb;
  import lfomc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } stereo_t;

  // one directed row: settings, sample, and optionally a typed-in result
  typedef struct {
    logic [1:0]  mode;
    logic [16:0] rate;
    logic [16:0] depth;
    logic [16:0] sr;
    logic [15:0] sample;
    bit          typed;
    logic [15:0] left;
    logic [15:0] right;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_MODE;
  logic [16:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  lfo_modulated_chorus u_dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always #5 clk = ~clk;

  // ---------------- predictor state ----------------
  logic signed [15:0] echo_mem [DELAY_DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [23:0]        lfo_a, lfo_b;
  logic [1:0]         cur_mode;
  logic [9:0]         cur_rate;
  logic [8:0]         cur_depth;
  logic [16:0]        cur_sr;

  stereo_t pending_q [$];
  int      n_errors = 0;
  int      n_cycles = 0;
  bit      calm = 1'b0;      // last part of the run: no idling on either side
  bit      hold_req = 1'b0;  // ask the sink to hold off for a long stretch

  // Q30 series sine rounded to Q15
  function automatic int sine_q15(int unsigned i);
    logic [63:0] ang, w, x, xx, t, s, q;
    logic [1:0]  qd;
    ang = (64'(i) << 32) / 64'(SINE_TABLE_SIZE);
    qd  = ang[31:30];
    w   = ang & 64'h3FFF_FFFF;
    if (qd[0]) w = 64'h4000_0000 - w;
    x  = (w * 64'd1686629713) >> 30;
    xx = (x * x) >> 30;
    t  = 64'h4000_0000 - xx / 64'd72;
    t  = 64'h4000_0000 - ((xx * t) >> 30) / 64'd42;
    t  = 64'h4000_0000 - ((xx * t) >> 30) / 64'd20;
    t  = 64'h4000_0000 - ((xx * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return qd[1] ? -int'(q) : int'(q);
  endfunction

  function automatic longint unsigned clamp_q8(longint unsigned d);
    if (d < 256) return 256;
    if (d > longint'(DELAY_DEPTH - 1) * 256) return longint'(DELAY_DEPTH - 1) * 256;
    return d;
  endfunction

  // interpolated read, Q8
  function automatic longint tap_q8(longint unsigned d);
    int unsigned di;
    longint      fr, x1, x2;
    logic [AW-1:0] p1, p2;
    di = int'(d >> 8);
    fr = longint'(d & 255);
    p1 = wr_ptr - AW'(di);
    p2 = p1 - 1'b1;
    x1 = echo_mem[p1];
    x2 = echo_mem[p2];
    return x1 * 256 + fr * (x2 - x1);
  endfunction

  function automatic logic [15:0] round_sat(longint acc);
    longint v;
    v = (acc + (64'sd1 <<< 22)) >>> 23;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // advance the chorus state by one sample and give the stereo word
  function automatic stereo_t chorus_next(logic [15:0] smp);
    stereo_t     r;
    longint      x, va, vb, ms, sa, sb;
    longint unsigned rate, dep, sr, step, da, db;
    x = longint'($signed(smp));
    echo_mem[wr_ptr] = smp;
    wr_ptr = wr_ptr + 1'b1;
    if (cur_mode != MODE_SINGLE && cur_mode != MODE_DUAL) begin
      r.left = smp;
      r.right = smp;
      return r;
    end
    rate = cur_rate;
    if (rate < 10) rate = 10;
    if (rate > 1000) rate = 1000;
    dep = (cur_depth > 256) ? 256 : cur_depth;
    sr = cur_sr;
    step = (sr != 0) ? (rate << 24) / (sr * 100) : 0;
    lfo_a = lfo_a + 24'(step);
    lfo_b = lfo_b + 24'(step);
    sa = sine_q15(lfo_a[23:16]);
    sb = sine_q15(lfo_b[23:16]);
    ms = (64'sd5 <<< 23) + 2 * sa * longint'(dep);
    da = clamp_q8((longint'(ms) * sr) / (64'd1000 << 15));
    va = tap_q8(da);
    if (cur_mode == MODE_SINGLE) begin
      r.left = round_sat(x * 256 * 22938 + va * 9830);
      r.right = r.left;
      return r;
    end
    ms = 5 * (64'sd13 <<< 22) + 8 * sb * longint'(dep);
    db = clamp_q8((longint'(ms) * sr) / (64'd5000 << 15));
    vb = tap_q8(db);
    r.left = round_sat(x * 256 * 19661 + va * 9830 + vb * 3277);
    r.right = round_sat(x * 256 * 19661 + vb * 9830 + va * 3277);
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    n_errors++;
    $display("MISMATCH %s at %0t: got %h want %h", what, $realtime, got, want);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    stereo_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_q.size() == 0) begin
        report("unexpected word", got.left, 16'h0000);
      end else begin
        want = pending_q.pop_front();
        if (got.left !== want.left) report("left_out", got.left, want.left);
        if (got.right !== want.right) report("right_out", got.right, want.right);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- sink: random stalls, one long hold-off ----------------
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // ---------------- source side ----------------
  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:  cur_mode = val[1:0];
      CFG_RATE:  cur_rate = val[9:0];
      CFG_DEPTH: cur_depth = val[8:0];
      CFG_SR:    cur_sr = val;
      default:   ;
    endcase
  endtask

  // apply a full setting; only while idle
  task automatic apply_setting(logic [1:0] m, logic [16:0] rt, logic [16:0] dp,
                               logic [16:0] sr);
    wait_drained();
    write_reg(CFG_MODE, 17'(m));
    write_reg(CFG_RATE, rt);
    write_reg(CFG_DEPTH, dp);
    write_reg(CFG_SR, sr);
  endtask

  // offer one word; returns once it is taken, prediction queued
  task automatic send_word(logic [15:0] smp, bit typed, logic [15:0] l, logic [15:0] r);
    stereo_t e;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
    e = chorus_next(smp);
    if (typed) begin
      e.left = l;
      e.right = r;
    end
    pending_q.push_back(e);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  vec_t dir_tab [] = '{
    // after reset: bypass, output equals input
    '{2'd0, 17'd80, 17'd128, 17'd44100, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF},
    '{2'd0, 17'd80, 17'd128, 17'd44100, 16'h8000, 1'b1, 16'h8000, 16'h8000},
    '{2'd0, 17'd80, 17'd128, 17'd44100, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    // mode three acts as bypass
    '{2'd3, 17'd80, 17'd128, 17'd44100, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF},
    '{2'd3, 17'd80, 17'd128, 17'd44100, 16'h3039, 1'b1, 16'h3039, 16'h3039},
    // single tap
    '{2'd1, 17'd80, 17'd128, 17'd44100, 16'h7FFF, 1'b0, '0, '0},
    '{2'd1, 17'd80, 17'd128, 17'd44100, 16'h8000, 1'b0, '0, '0},
    '{2'd1, 17'd0, 17'd128, 17'd44100, 16'h1234, 1'b0, '0, '0},     // rate below range
    '{2'd1, 17'd1023, 17'd511, 17'd44100, 16'h7FFF, 1'b0, '0, '0},  // rate, depth saturate
    '{2'd1, 17'd1000, 17'd0, 17'd8000, 16'h8000, 1'b0, '0, '0},
    '{2'd1, 17'd10, 17'd256, 17'd0, 16'h4000, 1'b0, '0, '0},        // sample rate zero
    '{2'd1, 17'd1000, 17'd256, 17'h1FFFF, 16'hC000, 1'b0, '0, '0},
    // dual taps
    '{2'd2, 17'd80, 17'd128, 17'd44100, 16'h7FFF, 1'b0, '0, '0},
    '{2'd2, 17'd80, 17'd128, 17'd44100, 16'h8000, 1'b0, '0, '0},
    '{2'd2, 17'd1023, 17'd511, 17'd88200, 16'h7FFF, 1'b0, '0, '0},
    '{2'd2, 17'd5, 17'd0, 17'd8000, 16'h0001, 1'b0, '0, '0},
    '{2'd2, 17'd500, 17'd256, 17'd0, 16'h8000, 1'b0, '0, '0},
    '{2'd2, 17'd1000, 17'd256, 17'h1FFFF, 16'h7FFF, 1'b0, '0, '0},
    // back to bypass with a held-LFO setting
    '{2'd0, 17'd1000, 17'd256, 17'h1FFFF, 16'h5A5A, 1'b1, 16'h5A5A, 16'h5A5A}
  };

  initial begin
    int ph, k, n_words;
    logic [1:0]  m;
    logic [16:0] rt, dp, sr;
    for (k = 0; k < DELAY_DEPTH; k++) echo_mem[k] = '0;
    wr_ptr = '0;
    lfo_a = 24'h000000;
    lfo_b = 24'h800000;
    cur_mode = 2'd0;
    cur_rate = 10'd80;
    cur_depth = 9'd128;
    cur_sr = 17'd44100;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; settings change only between idle points
    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != cur_mode || dir_tab[i].rate[9:0] != cur_rate ||
          dir_tab[i].depth[8:0] != cur_depth || dir_tab[i].sr != cur_sr) begin
        in_tvalid <= 1'b0;
        apply_setting(dir_tab[i].mode, dir_tab[i].rate, dir_tab[i].depth, dir_tab[i].sr);
      end
      send_word(dir_tab[i].sample, dir_tab[i].typed, dir_tab[i].left, dir_tab[i].right);
    end
    in_tvalid <= 1'b0;

    // random phases, ~1300 words
    for (ph = 0; ph < 13; ph++) begin
      calm = (ph >= 11);
      case ($urandom_range(0, 9))
        0:       m = 2'd0;
        1:       m = 2'd3;
        2, 3, 4: m = MODE_SINGLE;
        default: m = MODE_DUAL;
      endcase
      rt = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(10, 1000));
      dp = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 256));
      case ($urandom_range(0, 7))
        0:       sr = 17'($urandom);
        1:       sr = 17'd0;
        default: sr = 17'($urandom_range(8000, 88200));
      endcase
      apply_setting(m, rt, dp, sr);
      if (ph == 3) hold_req = 1'b1;  // sink stalls; block fills and backs up input
      n_words = $urandom_range(80, 120);
      for (k = 0; k < n_words; k++) send_word(rand_sample(), 1'b0, '0, '0);
      in_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
